### hdl/assert_macros.svh
// Assertion macros shared by the smoother RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// The antecedent implies the consequent in the same cycle.
`define WSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// The condition must never hold.
`define WSS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`endif

### hdl/wss_pkg.sv
// Shared types, constants and helpers of the weighted symmetric smoother.
package wss_pkg;

  localparam int KL_W      = 4;
  localparam int WT_W      = 16;
  localparam int NUM_WTS   = 8;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int WSUM_W    = 21;
  localparam int JOB_OFF_W  = 4;
  localparam int JOB_SEEN_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_HIGH = 2'd2;

  // One output to compute: the center offset in the window, how many
  // samples of the sequence the window held, and the end-of-sequence flag.
  typedef struct packed {
    logic [JOB_SEEN_W-1:0] seen;
    logic [JOB_OFF_W-1:0]  off;
    logic                  fin;
  } job_t;

  // Half-kernel weight j; weights past the eighth are zero.
  function automatic logic [WT_W-1:0] weight_sel(
    input logic [2*CFG_W-1:0] wts,
    input logic [7:0]         j
  );
    logic [WT_W-1:0] w;
    w = '0;
    if (j < 8'(NUM_WTS)) begin
      w = wts[j[2:0]*WT_W +: WT_W];
    end
    return w;
  endfunction

endpackage

### hdl/wss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 15
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/wss_fifo.sv
// Small flip-flop queue with push/full and pop/empty sides.
module wss_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### hdl/wss_front.sv
// Front end: takes samples into the window and queues the outputs they release.
module wss_front #(
  parameter int MAX_TAPS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  input  logic                          drained_i,
  input  logic [$clog2(MAX_TAPS+1)-1:0] k_i,
  output logic                          ram_we_o,
  output logic [((2*MAX_TAPS-1) > 1 ? $clog2(2*MAX_TAPS-1) : 1)-1:0] ram_waddr_o,
  output logic [SAMPLE_BITS-1:0]        ram_wdata_o,
  output logic [((2*MAX_TAPS-1) > 1 ? $clog2(2*MAX_TAPS-1) : 1)-1:0] wp_o,
  output logic                          job_push_o,
  output wss_pkg::job_t                 job_o,
  input  logic                          job_full_i
);

  localparam int W   = 2*MAX_TAPS - 1;
  localparam int AWD = (W > 1) ? $clog2(W) : 1;
  localparam int SW  = $clog2(W + 1);
  localparam int KW  = $clog2(MAX_TAPS + 1);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_GEN  = 1'b1;

  logic [0:0]     state_q, state_d;
  logic [AWD-1:0] wp_q, wp_d;
  logic [SW-1:0]  seen_q, seen_d;
  logic [KW-1:0]  cp_q, cp_d;
  logic           last_q, last_d;
  logic           accept, release_one;

  assign full_o      = !((state_q == ST_IDLE) && drained_i);
  assign accept      = push_i && !full_o;
  assign ram_we_o    = accept;
  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = sample_i;
  assign wp_o        = wp_q;

  // A pending output is released while enough samples follow it, or always
  // when the sequence ends.
  assign release_one = last_q ? (cp_q != '0) : ((cp_q >= k_i) && (cp_q != '0));

  always_comb begin
    state_d    = state_q;
    wp_d       = wp_q;
    seen_d     = seen_q;
    cp_d       = cp_q;
    last_d     = last_q;
    job_push_o = 1'b0;
    job_o.seen = wss_pkg::JOB_SEEN_W'(seen_q);
    job_o.off  = wss_pkg::JOB_OFF_W'(cp_q - 1'b1);
    job_o.fin  = last_q && (cp_q == KW'(1));
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wp_d   = (wp_q == AWD'(W - 1)) ? '0 : wp_q + 1'b1;
          seen_d = (seen_q == SW'(W)) ? seen_q : seen_q + 1'b1;
          cp_d   = (cp_q == KW'(MAX_TAPS)) ? cp_q : cp_q + 1'b1;
          last_d = last_i;
          state_d = ST_GEN;
        end
      end
      ST_GEN: begin
        if (release_one) begin
          if (!job_full_i) begin
            job_push_o = 1'b1;
            cp_d = cp_q - 1'b1;
          end
        end else begin
          if (last_q) begin
            seen_d = '0;
            cp_d   = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      seen_q  <= '0;
      cp_q    <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      seen_q  <= seen_d;
      cp_q    <= cp_d;
      last_q  <= last_d;
    end
  end

endmodule

### hdl/wss_back.sv
// Back end: one multiply-accumulate pass over the taps, then a serial divide unless the weight sum is zero.
module wss_back #(
  parameter int MAX_TAPS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  wss_pkg::job_t                 job_i,
  output logic                          job_pop_o,
  input  logic [$clog2(MAX_TAPS+1)-1:0] k_i,
  input  logic [2*wss_pkg::CFG_W-1:0]   weights_i,
  input  logic [((2*MAX_TAPS-1) > 1 ? $clog2(2*MAX_TAPS-1) : 1)-1:0] wp_i,
  output logic [((2*MAX_TAPS-1) > 1 ? $clog2(2*MAX_TAPS-1) : 1)-1:0] ram_raddr_o,
  input  logic signed [SAMPLE_BITS-1:0] ram_rdata_i,
  input  logic                          out_full_i,
  output logic                          res_push_o,
  output logic [SAMPLE_BITS:0]          res_o,
  output logic                          idle_o
);

  localparam int W   = 2*MAX_TAPS - 1;
  localparam int AWD = (W > 1) ? $clog2(W) : 1;
  localparam int SW  = $clog2(W + 1);
  localparam int KW  = $clog2(MAX_TAPS + 1);
  localparam int OW  = SW + 1;
  localparam int SCW = KW + 1;
  localparam int PW  = SAMPLE_BITS + wss_pkg::WT_W + 1;
  localparam int AW  = PW + 5;
  localparam int NW  = AW + 1;
  localparam int DW  = wss_pkg::WSUM_W + 1;
  localparam int QW  = SAMPLE_BITS + 1;
  localparam int CW  = $clog2(QW + 1);
  localparam int SB  = SAMPLE_BITS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_SAT   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                 state_q, state_d;
  logic [KW-1:0]              off_q;
  logic [SW-1:0]              seen_q;
  logic                       fin_q;
  logic [SCW-1:0]             s_q;
  logic [wss_pkg::WSUM_W-1:0] wsum_q;
  logic signed [AW-1:0]       acc_q;
  logic                       p1_v_q, p1_c_q, p2_v_q;
  logic [wss_pkg::WT_W-1:0]   p1_w_q;
  logic signed [PW-1:0]       prod_q;
  logic signed [SB-1:0]       raw_q;
  logic                       neg_q;
  logic [DW-1:0]              r_q;
  logic [QW-1:0]              nq_q;
  logic [CW-1:0]              cnt_q;
  logic [SB:0]                res_q;

  // Tap address generation.
  logic [KW-1:0]            j;
  logic                     side;
  logic [OW-1:0]            o_old, o, age, t;
  logic                     tap_ok;
  logic [wss_pkg::WT_W-1:0] w;
  logic                     mac_last;

  assign j        = s_q[SCW-1:1];
  assign side     = s_q[0];
  assign o_old    = OW'(off_q) + OW'(j);
  assign tap_ok   = side ? ((j != '0) && (o_old < OW'(seen_q)) && (o_old < OW'(W)))
                         : (j <= off_q);
  assign o        = !tap_ok ? OW'(off_q) : (side ? o_old : OW'(off_q) - OW'(j));
  assign age      = OW'(W - 1) - o;
  assign t        = OW'(wp_i) + age;
  assign ram_raddr_o = (t >= OW'(W)) ? AWD'(t - OW'(W)) : AWD'(t);
  assign w        = tap_ok ? wss_pkg::weight_sel(weights_i, 8'(j)) : '0;
  assign mac_last = (s_q == SCW'({k_i, 1'b0} - 1'b1));

  // Divider step and divide setup.
  logic [AW-1:0] mag;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [DW:0]   rr;
  logic          qbit;

  assign mag  = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
  assign num  = {mag, 1'b0} + NW'(wsum_q);
  assign den  = {wsum_q, 1'b0};
  assign rr   = {r_q, nq_q[QW-1]};
  assign qbit = (rr >= (DW+1)'(den));

  // Rounded magnitude to the signed sample range.
  logic [SB-1:0] sat;
  always_comb begin
    if (!neg_q) begin
      sat = (nq_q > QW'((1 << (SB - 1)) - 1)) ? SB'((1 << (SB - 1)) - 1) : SB'(nq_q);
    end else begin
      sat = (nq_q >= QW'(1 << (SB - 1))) ? SB'(1 << (SB - 1)) : SB'(-nq_q);
    end
  end

  assign idle_o     = (state_q == ST_IDLE);
  assign job_pop_o  = (state_q == ST_IDLE) && job_valid_i;
  assign res_push_o = (state_q == ST_OUT) && !out_full_i;
  assign res_o      = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = ST_MAC;
      ST_MAC:   if (mac_last) state_d = ST_DRAIN;
      ST_DRAIN: if (!p1_v_q && !p2_v_q) state_d = ST_PREP;
      ST_PREP:  state_d = (wsum_q == '0) ? ST_OUT : ST_DIV;
      ST_DIV:   if (cnt_q == CW'(QW - 1)) state_d = ST_SAT;
      ST_SAT:   state_d = ST_OUT;
      ST_OUT:   if (!out_full_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_v_q  <= (state_q == ST_MAC);
      p2_v_q  <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_w_q <= w;
    p1_c_q <= !side && (j == '0);
    prod_q <= PW'($signed({1'b0, p1_w_q})) * PW'(ram_rdata_i);
    if (p1_v_q && p1_c_q) begin
      raw_q <= ram_rdata_i;
    end
    if (p2_v_q) begin
      acc_q <= acc_q + AW'(prod_q);
    end
    unique case (state_q)
      ST_IDLE: begin
        off_q  <= KW'(job_i.off);
        seen_q <= SW'(job_i.seen);
        fin_q  <= job_i.fin;
        s_q    <= '0;
        wsum_q <= '0;
        acc_q  <= '0;
      end
      ST_MAC: begin
        s_q    <= s_q + 1'b1;
        wsum_q <= wsum_q + wss_pkg::WSUM_W'(w);
      end
      ST_PREP: begin
        neg_q <= acc_q[AW-1];
        r_q   <= DW'(num >> QW);
        nq_q  <= num[QW-1:0];
        cnt_q <= '0;
        res_q <= {fin_q, raw_q};
      end
      ST_DIV: begin
        r_q   <= qbit ? DW'(rr - (DW+1)'(den)) : DW'(rr);
        nq_q  <= {nq_q[QW-2:0], qbit};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_SAT: res_q <= {fin_q, sat};
      default: ;
    endcase
  end

endmodule

### hdl/weighted_symmetric_smoother.sv
// Top level of the weighted symmetric smoother.
// Usage:
// Samples enter through a queue-like port: a beat moves on push while full is low.
// Results leave the same way: smoothed_o/final_res_o are valid while empty is low,
// and a beat moves on pop. Configuration is written with cfg_we_i, cfg_idx_i and
// cfg_data_i while the block is idle (kernel length, weights 0..3, weights 4..7).
// A result for a sample appears once K-1 newer samples have arrived, K being the
// kernel length; a sample with last set flushes every pending result, and the
// final one carries final_res_o.
// Each result takes 2*K tap reads through the single multiply-accumulate unit,
// a drain of the product pipeline, and a restoring divider that retires one
// quotient bit per cycle; the divider is skipped when the weight sum is zero.
// A sample is taken only once all results released before it have been computed.
// Reset clears the sequence state and sets K = 1, weight 0 = 1, other weights 0.
// A stalled receiver fills the two-entry result queue, which halts the divider
// back end and can fill the job queue; full stays high until both are drained.
module weighted_symmetric_smoother #(
  parameter int MAX_TAPS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  logic                             last_i,
  output logic                             empty,
  input  logic                             pop,
  output logic signed [SAMPLE_BITS-1:0]    smoothed_o,
  output logic                             final_res_o,
  input  logic                             cfg_we_i,
  input  logic [wss_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wss_pkg::CFG_W-1:0]        cfg_data_i
);

`include "assert_macros.svh"

  localparam int W   = 2*MAX_TAPS - 1;
  localparam int AWD = (W > 1) ? $clog2(W) : 1;
  localparam int KW  = $clog2(MAX_TAPS + 1);
  localparam int JW  = $bits(wss_pkg::job_t);

  logic [wss_pkg::KL_W-1:0]  kernel_len_q;
  logic [wss_pkg::CFG_W-1:0] weights_low_q, weights_high_q;
  logic [KW-1:0]             k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_len_q   <= wss_pkg::KL_W'(1);
      weights_low_q  <= wss_pkg::CFG_W'(1);
      weights_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wss_pkg::CFG_KERNEL_LEN:   kernel_len_q   <= cfg_data_i[wss_pkg::KL_W-1:0];
        wss_pkg::CFG_WEIGHTS_LOW:  weights_low_q  <= cfg_data_i;
        wss_pkg::CFG_WEIGHTS_HIGH: weights_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one, and lengths above the window's reach are clipped.
  always_comb begin
    if (kernel_len_q == '0) begin
      k = KW'(1);
    end else if (32'(kernel_len_q) > MAX_TAPS) begin
      k = KW'(MAX_TAPS);
    end else begin
      k = KW'(kernel_len_q);
    end
  end

  logic                   ram_we;
  logic [AWD-1:0]         ram_waddr, ram_raddr, wp;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic signed [SAMPLE_BITS-1:0] ram_rdata;
  logic                   job_push, job_full, job_pop, job_empty;
  wss_pkg::job_t          job_in, job_out;
  logic [JW-1:0]          job_raw;
  logic                   back_idle, res_push, out_full;
  logic [SAMPLE_BITS:0]   res, out_data;

  wss_front #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .drained_i   (job_empty && back_idle),
    .k_i         (k),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .wp_o        (wp),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  wss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(W)) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wss_fifo #(.WIDTH(JW), .DEPTH(4)) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_raw),
    .empty_o (job_empty)
  );

  assign job_out = wss_pkg::job_t'(job_raw);

  wss_back #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .k_i         (k),
    .weights_i   ({weights_high_q, weights_low_q}),
    .wp_i        (wp),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_full_i  (out_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .idle_o      (back_idle)
  );

  wss_fifo #(.WIDTH(SAMPLE_BITS + 1), .DEPTH(2)) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign smoothed_o  = out_data[SAMPLE_BITS-1:0];
  assign final_res_o = out_data[SAMPLE_BITS];

  `WSS_ASSERT_IMPLY(a_accept_drained, push && !full, job_empty && back_idle, "busy accept")
  `WSS_ASSERT_NEVER(a_job_overflow, job_push && job_full, "job pushed into full queue")
  `WSS_ASSERT_IMPLY(a_job_pop_valid, job_pop, !job_empty && back_idle, "pop of no job")

endmodule
